// File: src/bebnd_pkg.sv
// ---------------------------------------------------------------------------
// bebnd_pkg: shared types and constants
// Request/result payloads, mode and register codes, sequencer states,
// controller command and datapath status groups, neighbor offset tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bebnd_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       last;
	} rsp_t;

	localparam logic       KIND_LOAD = 1'b0;
	localparam logic       KIND_READ = 1'b1;

	localparam logic [1:0] MODE_ERODE4   = 2'd0;
	localparam logic [1:0] MODE_ERODE8   = 2'd1;

	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_PASSES    = 2'd1;
	localparam logic [1:0] REG_WIDTH     = 2'd2;
	localparam logic [1:0] REG_HEIGHT    = 2'd3;

	localparam logic [7:0] PIX_OBJECT    = 8'd0;
	localparam logic [7:0] PIX_BACKGND   = 8'd255;

	// neighbor offsets; the first four are the 4-neighbors
	localparam logic signed [1:0] NB_ROW [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
		-2'sd1, 2'sd1, 2'sd1, -2'sd1};
	localparam logic signed [1:0] NB_COL [8] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
		2'sd1, 2'sd1, -2'sd1, -2'sd1};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PCHK,
		ST_MCTR,
		ST_MCTR_CHK,
		ST_MNB,
		ST_MNB_CHK,
		ST_MWR,
		ST_ARD,
		ST_AWR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rdout;
		logic pass_clr;
		logic pass_inc;
		logic pix_clr;
		logic pix_inc;
		logic k_clr;
		logic k_inc;
		logic rd_center;
		logic rd_nb;
		logic acc_clr;
		logic acc_upd;
		logic mark_wr;
		logic mark_rd;
		logic apply_wr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic load_done;
		logic passes_done;
		logic center_zero;
		logic last_nb;
		logic last_pix;
	} sts_t;

endpackage

`default_nettype wire

// File: src/bebnd_ctrl.sv
// ---------------------------------------------------------------------------
// bebnd_ctrl: pass sequencer
// Steps the datapath through loading, mark and apply sweeps and readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bebnd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            kind,
	input  wire bebnd_pkg::sts_t sts,
	output bebnd_pkg::cmd_t      cmd,
	output logic                 busy
);
	import bebnd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && kind == KIND_LOAD && sts.load_done) state_d = ST_PCHK;
			end
			ST_PCHK:     state_d = sts.passes_done ? ST_FIN : ST_MCTR;
			ST_MCTR:     state_d = ST_MCTR_CHK;
			ST_MCTR_CHK: state_d = sts.center_zero ? ST_MNB : ST_MWR;
			ST_MNB:      state_d = ST_MNB_CHK;
			ST_MNB_CHK:  state_d = sts.last_nb ? ST_MWR : ST_MNB;
			ST_MWR:      state_d = sts.last_pix ? ST_ARD : ST_MCTR;
			ST_ARD:      state_d = ST_AWR;
			ST_AWR:      state_d = sts.last_pix ? ST_PCHK : ST_ARD;
			ST_FIN:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load     = start && kind == KIND_LOAD;
				cmd.rdout    = start && kind == KIND_READ;
				cmd.pass_clr = 1'b1;
			end
			ST_PCHK: cmd.pix_clr = 1'b1;
			ST_MCTR: begin
				cmd.rd_center = 1'b1;
				cmd.acc_clr   = 1'b1;
				cmd.k_clr     = 1'b1;
			end
			ST_MCTR_CHK: ;
			ST_MNB:      cmd.rd_nb = 1'b1;
			ST_MNB_CHK: begin
				cmd.acc_upd = 1'b1;
				cmd.k_inc   = 1'b1;
			end
			ST_MWR: begin
				cmd.mark_wr = 1'b1;
				cmd.pix_clr = sts.last_pix;
				cmd.pix_inc = !sts.last_pix;
			end
			ST_ARD: cmd.mark_rd = 1'b1;
			ST_AWR: begin
				cmd.apply_wr = 1'b1;
				cmd.pass_inc = sts.last_pix;
				cmd.pix_inc  = !sts.last_pix;
			end
			ST_FIN:  cmd.finish = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: src/bebnd_dp.sv
// ---------------------------------------------------------------------------
// bebnd_dp: frame datapath
// Config registers, frame and mark memories, scan counters, neighbor
// addressing and the readout register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bebnd_dp #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bebnd_pkg::cmd_t cmd,
	input  wire logic [7:0]      pixel_in,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [7:0]      cfg_data,
	output bebnd_pkg::sts_t      sts,
	output logic                 result_valid,
	output bebnd_pkg::rsp_t      result
);
	import bebnd_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int IW    = $clog2(DEPTH);
	localparam int AW    = $clog2(DEPTH + 1);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int XW    = (WW > 8) ? WW : 8;
	localparam int YW    = (HW > 8) ? HW : 8;

	logic [1:0] mode_q;
	logic [7:0] passes_q, fw_q, fh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ERODE4;
			passes_q <= 8'd1;
			fw_q     <= 8'd100;
			fh_q     <= 8'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_PASSES: passes_q <= cfg_data;
				REG_WIDTH:  fw_q     <= cfg_data;
				REG_HEIGHT: fh_q     <= cfg_data;
				default:    ;
			endcase
		end
	end

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [AW-1:0] total;
	logic          boundary, conn8;
	logic [7:0]    npass;

	always_comb begin
		if (fw_q == 8'd0)                   eff_w = WW'(1);
		else if (XW'(fw_q) > XW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
		else                                eff_w = WW'(XW'(fw_q));
		if (fh_q == 8'd0)                    eff_h = HW'(1);
		else if (YW'(fh_q) > YW'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
		else                                 eff_h = HW'(YW'(fh_q));
	end

	assign total    = AW'(eff_w) * AW'(eff_h);
	assign boundary = (mode_q != MODE_ERODE4) && (mode_q != MODE_ERODE8);
	assign conn8    = (mode_q == MODE_ERODE8);
	assign npass    = boundary ? 8'd1 : passes_q;

	// load / readout indices and frame-ready flag
	logic [IW-1:0] li_q, ri_q, li_eff, ri_eff;
	logic          ready_q;
	logic          rd_last;

	assign li_eff  = (AW'(li_q) >= total) ? '0 : li_q;
	assign ri_eff  = (AW'(ri_q) >= total) ? '0 : ri_q;
	assign rd_last = (AW'(ri_eff) == total - AW'(1));

	// scan position and pass count
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [IW-1:0] pix_q;
	logic [2:0]    k_q;
	logic [7:0]    pass_q;
	logic          acc_q, inb_q;
	logic          last_col, last_row;

	assign last_col = (WW'(c_q) == eff_w - WW'(1));
	assign last_row = (HW'(r_q) == eff_h - HW'(1));

	// memory read registers
	logic [7:0] frame_rd_q;
	logic       mark_rd_q;

	// neighbor address and frame-edge check
	logic signed [1:0] dr, dc;
	logic [IW-1:0]     nb_row_base, nb_addr;
	logic              nb_inb;

	always_comb begin
		dr = NB_ROW[k_q];
		dc = NB_COL[k_q];
		nb_inb = !((dr == -2'sd1) && (r_q == '0)) && !((dr == 2'sd1) && last_row) &&
			!((dc == -2'sd1) && (c_q == '0)) && !((dc == 2'sd1) && last_col);
		if (dr == -2'sd1)     nb_row_base = pix_q - IW'(eff_w);
		else if (dr == 2'sd1) nb_row_base = pix_q + IW'(eff_w);
		else                  nb_row_base = pix_q;
		if (dc == -2'sd1)     nb_addr = nb_row_base - IW'(1);
		else if (dc == 2'sd1) nb_addr = nb_row_base + IW'(1);
		else                  nb_addr = nb_row_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			li_q    <= '0;
			ri_q    <= '0;
			ready_q <= 1'b0;
			r_q     <= '0;
			c_q     <= '0;
			pix_q   <= '0;
			k_q     <= '0;
			pass_q  <= '0;
			acc_q   <= 1'b0;
			inb_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				ready_q <= 1'b0;
				li_q    <= sts.load_done ? '0 : li_eff + IW'(1);
			end
			if (cmd.rdout && ready_q) ri_q <= rd_last ? '0 : ri_eff + IW'(1);
			if (cmd.finish) begin
				ready_q <= 1'b1;
				li_q    <= '0;
				ri_q    <= '0;
			end
			if (cmd.pass_clr) pass_q <= '0;
			else if (cmd.pass_inc) pass_q <= pass_q + 8'd1;
			if (cmd.pix_clr) begin
				r_q   <= '0;
				c_q   <= '0;
				pix_q <= '0;
			end else if (cmd.pix_inc) begin
				pix_q <= pix_q + IW'(1);
				if (last_col) begin
					c_q <= '0;
					r_q <= r_q + RW'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
			if (cmd.k_clr) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + 3'd1;
			if (cmd.acc_clr) acc_q <= 1'b0;
			else if (cmd.acc_upd) acc_q <= acc_q | (inb_q && frame_rd_q == PIX_BACKGND);
			if (cmd.rd_nb) inb_q <= nb_inb;
		end
	end

	// frame memory: one write, one registered read
	logic [7:0]    frame_mem [DEPTH];
	logic [IW-1:0] f_waddr, f_raddr;
	logic [7:0]    f_wdata;
	logic          f_we, f_re;

	always_comb begin
		f_we    = 1'b0;
		f_waddr = pix_q;
		f_wdata = pixel_in;
		if (cmd.load) begin
			f_we    = 1'b1;
			f_waddr = li_eff;
		end else if (cmd.apply_wr) begin
			f_we    = boundary || mark_rd_q;
			f_wdata = (boundary && mark_rd_q) ? PIX_OBJECT : PIX_BACKGND;
		end
		f_re    = cmd.rd_center || cmd.rd_nb || (cmd.rdout && ready_q);
		f_raddr = cmd.rd_nb ? nb_addr : (cmd.rd_center ? pix_q : ri_eff);
	end

	always_ff @(posedge clk) begin
		if (f_we) frame_mem[f_waddr] <= f_wdata;
		if (f_re) frame_rd_q <= frame_mem[f_raddr];
	end

	// mark memory: every entry of a pass is written before it is read
	logic mark_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.mark_wr) mark_mem[pix_q] <= acc_q;
		if (cmd.mark_rd) mark_rd_q <= mark_mem[pix_q];
	end

	// readout strobe and last flag
	logic valid_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= cmd.rdout && ready_q;
			last_q  <= rd_last;
		end
	end

	assign result_valid     = valid_q;
	assign result.pixel_out = frame_rd_q;
	assign result.last      = last_q;

	assign sts.load_done   = (AW'(li_eff) + AW'(1) == total);
	assign sts.passes_done = (pass_q == npass);
	assign sts.center_zero = (frame_rd_q == PIX_OBJECT);
	assign sts.last_nb     = (k_q == (conn8 ? 3'd7 : 3'd3));
	assign sts.last_pix    = (AW'(pix_q) == total - AW'(1));

endmodule

`default_nettype wire

// File: src/binary_erosion_boundary_top.sv
// ---------------------------------------------------------------------------
// binary_erosion_boundary_top: binary erosion / boundary extraction engine
// Loads a frame, runs erosion or boundary passes, then streams it back.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. kind 0 loads the
//   next pixel in raster order; kind 1 reads the next result pixel. A read
//   gives result_valid for one cycle, in the cycle after the request, with
//   pixel_out and last; reads may follow every cycle. A read before a frame
//   is processed gives no result.
//   The request that loads the final pixel starts the passes and busy stays
//   high until they end. For each pixel a mark sweep reads the center and,
//   for an object pixel, its N neighbors (N = 4 or 8) in turn through the
//   single frame memory read port, then writes the mark; the apply sweep
//   reads each mark and updates the pixel. Config (cfg_we/cfg_index/cfg_data)
//   is to be written by the user only while idle, no wait; the block itself
//   does not enforce it. Reset clears control and loads the register defaults;
//   frame memory content is undefined until loaded. Results cannot be stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_erosion_boundary_top #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire bebnd_pkg::req_t req,
	output logic                 result_valid,
	output bebnd_pkg::rsp_t      result,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [7:0]      cfg_data
);
	import bebnd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bebnd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bebnd_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.pixel_in     (req.pixel_in),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

	// a result only follows an accepted read request
	a_result_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && req.kind == KIND_READ))
		else $error("result without read request");

	// processing only begins after a load request
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && req.kind == KIND_LOAD))
		else $error("busy raised without load request");

	// no result is strobed while passes are running
	a_no_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> !result_valid)
		else $error("result during processing");

endmodule

`default_nettype wire
